FILE: rtl/sfam_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the stove fire alarm monitor.
package sfam_pkg;

    // Field widths
    localparam int TEMP_W   = 15;
    localparam int OFFSET_W = 11;
    localparam int TIME_W   = 32;
    localparam int MODE_W   = 2;
    localparam int BEEP_W   = 2;
    // Width used for all temperature comparisons (sum plus hysteresis headroom)
    localparam int CMP_W    = 17;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 15;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FIRE_ON_LEVEL  = 3'd0,
        CFG_ALARM_LEVEL    = 3'd1,
        CFG_COLD_LEVEL     = 3'd2,
        CFG_TEMP_OFFSET    = 3'd3,
        CFG_OVERHEAT_LEVEL = 3'd4
    } cfg_idx_t;

    // Reset values of the configuration registers
    localparam logic signed [TEMP_W-1:0]   FIRE_ON_RST  = 15'sd800;
    localparam logic signed [TEMP_W-1:0]   ALARM_RST    = 15'sd800;
    localparam logic signed [TEMP_W-1:0]   COLD_RST     = 15'sd400;
    localparam logic signed [OFFSET_W-1:0] OFFSET_RST   = -11'sd50;
    localparam logic signed [TEMP_W-1:0]   OVERHEAT_RST = 15'sd1700;

    // Saturation limits of the corrected temperature output
    localparam logic signed [CMP_W-1:0] SAT_MAX = 17'sd16383;
    localparam logic signed [CMP_W-1:0] SAT_MIN = -17'sd16384;

    // Stove state, one-hot
    typedef enum logic [2:0] {
        MODE_OFF   = 3'b001,
        MODE_BURN  = 3'b010,
        MODE_ALERT = 3'b100
    } mode_t;

    // Reported mode codes
    localparam logic [MODE_W-1:0] MODE_CODE_OFF   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CODE_BURN  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CODE_ALERT = 2'd2;

    // Beep counts
    localparam logic [BEEP_W-1:0] BEEPS_NONE   = 2'd0;
    localparam logic [BEEP_W-1:0] BEEPS_SINGLE = 2'd1;
    localparam logic [BEEP_W-1:0] BEEPS_DOUBLE = 2'd2;

    typedef struct packed {
        logic signed [TEMP_W-1:0]   fire_on_level;
        logic signed [TEMP_W-1:0]   alarm_level;
        logic signed [TEMP_W-1:0]   cold_level;
        logic signed [OFFSET_W-1:0] temp_offset;
        logic signed [TEMP_W-1:0]   overheat_level;
    } cfg_t;

    typedef struct packed {
        mode_t             mode;
        logic [TIME_W-1:0] last_overheat_ms;
        logic [TIME_W-1:0] last_beep_ms;
    } state_t;

    // Result item; the last member sits in the lowest bits
    typedef struct packed {
        logic                     cold_sound;
        logic [BEEP_W-1:0]        alert_beeps;
        logic                     fire_start_sound;
        logic                     overheat_sound;
        logic signed [TEMP_W-1:0] corrected_temp;
        logic [MODE_W-1:0]        stove_mode;
    } result_t;

    localparam int RES_W      = $bits(result_t);
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 24;

endpackage

FILE: rtl/stove_fire_alarm_monitor_top.sv
`timescale 1ns / 1ps
// Top level of the stove fire alarm monitor: input register, step logic, result register.
// A request waits in the input register; its result is then held in the result register.
// Throughput: one request per cycle while m_axis_tready keeps the result register free;
// the step logic is a single pass of adds and compares.
// Reset: configuration registers return to their defaults, the stove is off,
// both timestamps are zero and the pipeline is empty.
module stove_fire_alarm_monitor_top #(
    parameter int REPEAT_MS       = 60000,
    parameter int EXIT_HYSTERESIS = 20
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // s_axis_tdata: raw_temp[14:0], now_ms[46:15], zero pad[47]
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [sfam_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // m_axis_tdata: stove_mode[1:0], corrected_temp[16:2], overheat_sound[17],
    // fire_start_sound[18], alert_beeps[20:19], cold_sound[21], zero pad[23:22]
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [sfam_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [sfam_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [sfam_pkg::CFG_DATA_W-1:0]     cfg_data
);

    sfam_pkg::cfg_t                     cfg;
    sfam_pkg::state_t                   state_reg;
    sfam_pkg::state_t                   state_next;
    sfam_pkg::result_t                  result;
    sfam_pkg::result_t                  out_res_reg;
    logic                               out_valid_reg;
    logic                               in_valid_reg;
    logic signed [sfam_pkg::TEMP_W-1:0] in_raw_reg;
    logic [sfam_pkg::TIME_W-1:0]        in_now_reg;
    logic                               out_free;
    logic                               advance;
    logic                               in_take;

    sfam_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    sfam_step #(
        .REPEAT_MS       (REPEAT_MS),
        .EXIT_HYSTERESIS (EXIT_HYSTERESIS)
    ) u_step (
        .raw_temp   (in_raw_reg),
        .now_ms     (in_now_reg),
        .cfg        (cfg),
        .state      (state_reg),
        .state_next (state_next),
        .result     (result)
    );

    // Pipeline flow control
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_raw_reg <= s_axis_tdata[sfam_pkg::TEMP_W-1:0];
            in_now_reg <= s_axis_tdata[sfam_pkg::TEMP_W +: sfam_pkg::TIME_W];
        end
    end

    // Stove state, updated as each request leaves the input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.mode             <= sfam_pkg::MODE_OFF;
            state_reg.last_overheat_ms <= '0;
            state_reg.last_beep_ms     <= '0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_res_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {(sfam_pkg::OUT_TDATA_W - sfam_pkg::RES_W)'(0), out_res_reg};

    // A request leaving the input register always lands in the result register.
    a_advance_fills: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("result register not filled after advance");

    // Fire start sound only goes with the burning mode.
    a_fire_mode: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_res_reg.fire_start_sound) |->
        (out_res_reg.stove_mode == sfam_pkg::MODE_CODE_BURN))
        else $error("fire start sound without burning mode");

    // Cold sound only goes with the off mode.
    a_cold_mode: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_res_reg.cold_sound) |->
        (out_res_reg.stove_mode == sfam_pkg::MODE_CODE_OFF))
        else $error("cold sound without off mode");

    // A single beep means the stove has just entered alert.
    a_single_beep: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_res_reg.alert_beeps == sfam_pkg::BEEPS_SINGLE) |->
        (out_res_reg.stove_mode == sfam_pkg::MODE_CODE_ALERT))
        else $error("single beep outside alert mode");

endmodule

FILE: rtl/sfam_cfg.sv
`timescale 1ns / 1ps
// Configuration register file of the stove fire alarm monitor.
module sfam_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [sfam_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sfam_pkg::CFG_DATA_W-1:0]  cfg_data,
    output sfam_pkg::cfg_t                   cfg
);

    sfam_pkg::cfg_t cfg_reg;

    // Writes are always taken; unknown indexes are dropped.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.fire_on_level  <= sfam_pkg::FIRE_ON_RST;
            cfg_reg.alarm_level    <= sfam_pkg::ALARM_RST;
            cfg_reg.cold_level     <= sfam_pkg::COLD_RST;
            cfg_reg.temp_offset    <= sfam_pkg::OFFSET_RST;
            cfg_reg.overheat_level <= sfam_pkg::OVERHEAT_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                sfam_pkg::CFG_FIRE_ON_LEVEL:
                    cfg_reg.fire_on_level <= cfg_data[sfam_pkg::TEMP_W-1:0];
                sfam_pkg::CFG_ALARM_LEVEL:
                    cfg_reg.alarm_level <= cfg_data[sfam_pkg::TEMP_W-1:0];
                sfam_pkg::CFG_COLD_LEVEL:
                    cfg_reg.cold_level <= cfg_data[sfam_pkg::TEMP_W-1:0];
                sfam_pkg::CFG_TEMP_OFFSET:
                    cfg_reg.temp_offset <= cfg_data[sfam_pkg::OFFSET_W-1:0];
                sfam_pkg::CFG_OVERHEAT_LEVEL:
                    cfg_reg.overheat_level <= cfg_data[sfam_pkg::TEMP_W-1:0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: rtl/sfam_step.sv
`timescale 1ns / 1ps
// Per-sample decision logic: offset correction, state update and sound flags.
module sfam_step #(
    parameter int REPEAT_MS       = 60000,
    parameter int EXIT_HYSTERESIS = 20
) (
    input  logic signed [sfam_pkg::TEMP_W-1:0] raw_temp,
    input  logic [sfam_pkg::TIME_W-1:0]        now_ms,
    input  sfam_pkg::cfg_t                     cfg,
    input  sfam_pkg::state_t                   state,
    output sfam_pkg::state_t                   state_next,
    output sfam_pkg::result_t                  result
);

    localparam logic [sfam_pkg::TIME_W-1:0] REPEAT = sfam_pkg::TIME_W'(REPEAT_MS);
    localparam logic signed [sfam_pkg::CMP_W-1:0] HYST =
        sfam_pkg::CMP_W'(EXIT_HYSTERESIS);

    logic signed [sfam_pkg::CMP_W-1:0] corr;
    logic signed [sfam_pkg::CMP_W-1:0] fire_lvl;
    logic signed [sfam_pkg::CMP_W-1:0] alarm_lvl;
    logic signed [sfam_pkg::CMP_W-1:0] exit_lvl;
    logic signed [sfam_pkg::CMP_W-1:0] cold_lvl;
    logic signed [sfam_pkg::CMP_W-1:0] oh_lvl;
    logic [sfam_pkg::TIME_W-1:0]       oh_age;
    logic [sfam_pkg::TIME_W-1:0]       beep_age;
    logic                              overheat;
    logic                              fire;
    logic                              cold;
    logic [sfam_pkg::BEEP_W-1:0]       beeps;
    logic [sfam_pkg::MODE_W-1:0]       mode_code;

    // Exact corrected sum and sign-extended thresholds
    assign corr      = sfam_pkg::CMP_W'(raw_temp) + sfam_pkg::CMP_W'(cfg.temp_offset);
    assign fire_lvl  = sfam_pkg::CMP_W'(cfg.fire_on_level);
    assign alarm_lvl = sfam_pkg::CMP_W'(cfg.alarm_level);
    assign exit_lvl  = alarm_lvl + HYST;
    assign cold_lvl  = sfam_pkg::CMP_W'(cfg.cold_level);
    assign oh_lvl    = sfam_pkg::CMP_W'(cfg.overheat_level);

    // Elapsed times, modulo 2^32
    assign oh_age   = now_ms - state.last_overheat_ms;
    assign beep_age = now_ms - state.last_beep_ms;

    // Rate-limited overheat announcement, in every mode
    assign overheat = (corr > oh_lvl) && (oh_age > REPEAT);

    // Mode machine
    always_comb
    begin
        state_next = state;
        fire  = 1'b0;
        cold  = 1'b0;
        beeps = sfam_pkg::BEEPS_NONE;
        if (overheat)
        begin
            state_next.last_overheat_ms = now_ms;
        end
        unique case (state.mode)
            sfam_pkg::MODE_BURN:
            begin
                if (corr < alarm_lvl)
                begin
                    state_next.mode         = sfam_pkg::MODE_ALERT;
                    state_next.last_beep_ms = now_ms;
                    beeps                   = sfam_pkg::BEEPS_SINGLE;
                end
            end
            sfam_pkg::MODE_ALERT:
            begin
                if (beep_age > REPEAT)
                begin
                    state_next.last_beep_ms = now_ms;
                    beeps                   = sfam_pkg::BEEPS_DOUBLE;
                end
                if (corr > exit_lvl)
                begin
                    state_next.mode = sfam_pkg::MODE_BURN;
                end
                else if (corr < cold_lvl)
                begin
                    state_next.mode = sfam_pkg::MODE_OFF;
                    cold            = 1'b1;
                end
            end
            default:
            begin
                // Off, and any unexpected encoding, behave as off.
                state_next.mode = sfam_pkg::MODE_OFF;
                if (corr > fire_lvl)
                begin
                    state_next.mode = sfam_pkg::MODE_BURN;
                    fire            = 1'b1;
                end
            end
        endcase
    end

    // Reported mode code
    always_comb
    begin
        unique case (state_next.mode)
            sfam_pkg::MODE_BURN:  mode_code = sfam_pkg::MODE_CODE_BURN;
            sfam_pkg::MODE_ALERT: mode_code = sfam_pkg::MODE_CODE_ALERT;
            default:              mode_code = sfam_pkg::MODE_CODE_OFF;
        endcase
    end

    // Result item, with the reported temperature saturated to 15 bits
    always_comb
    begin
        result.stove_mode       = mode_code;
        result.overheat_sound   = overheat;
        result.fire_start_sound = fire;
        result.alert_beeps      = beeps;
        result.cold_sound       = cold;
        if (corr > sfam_pkg::SAT_MAX)
        begin
            result.corrected_temp = sfam_pkg::SAT_MAX[sfam_pkg::TEMP_W-1:0];
        end
        else if (corr < sfam_pkg::SAT_MIN)
        begin
            result.corrected_temp = sfam_pkg::SAT_MIN[sfam_pkg::TEMP_W-1:0];
        end
        else
        begin
            result.corrected_temp = corr[sfam_pkg::TEMP_W-1:0];
        end
    end

endmodule
